// File: sv/sinci_pkg.sv
package sinci_pkg;

    localparam int DIVIDEND_W = 20;
    localparam int INV_PI_Q16 = 20861;

    localparam logic [1:0] CFG_TIMEBASE    = 2'd0;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] sample;
        logic [9:0] position;
    } sinci_in_t;

    typedef struct packed {
        logic [7:0] value;
        logic [9:0] point;
    } sinci_out_t;

    typedef struct packed {
        logic accept_load;
        logic accept_read;
        logic div_start_mk;
        logic mk_latch;
        logic div_start_j;
        logic sine_load;
        logic const1;
        logic const2;
        logic mem_rd_grid;
        logic grid_res;
        logic mem_rd_term;
        logic term_mul;
        logic term_div;
        logic term_acc;
        logic sum_res;
        logic out_load;
    } sinci_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic k_zero;
        logic count_zero;
        logic last_term;
    } sinci_status_t;

    function automatic logic [5:0] delta_of(input logic [2:0] sel);
        logic [5:0] d;
        unique case (sel)
            3'd0:    d = 6'd50;
            3'd1:    d = 6'd20;
            3'd2:    d = 6'd10;
            3'd3:    d = 6'd5;
            default: d = 6'd2;
        endcase
        return d;
    endfunction

    function automatic logic [14:0] sine_q15(input logic [5:0] j);
        logic [14:0] s;
        unique case (j)
            6'd0:  s = 15'd0;     6'd1:  s = 15'd1029;  6'd2:  s = 15'd2057;
            6'd3:  s = 15'd3084;  6'd4:  s = 15'd4107;  6'd5:  s = 15'd5126;
            6'd6:  s = 15'd6140;  6'd7:  s = 15'd7148;  6'd8:  s = 15'd8149;
            6'd9:  s = 15'd9142;  6'd10: s = 15'd10126; 6'd11: s = 15'd11099;
            6'd12: s = 15'd12062; 6'd13: s = 15'd13013; 6'd14: s = 15'd13952;
            6'd15: s = 15'd14876; 6'd16: s = 15'd15786; 6'd17: s = 15'd16680;
            6'd18: s = 15'd17557; 6'd19: s = 15'd18418; 6'd20: s = 15'd19260;
            6'd21: s = 15'd20083; 6'd22: s = 15'd20886; 6'd23: s = 15'd21669;
            6'd24: s = 15'd22431; 6'd25: s = 15'd23170; 6'd26: s = 15'd23886;
            6'd27: s = 15'd24579; 6'd28: s = 15'd25247; 6'd29: s = 15'd25891;
            6'd30: s = 15'd26509; 6'd31: s = 15'd27101; 6'd32: s = 15'd27666;
            6'd33: s = 15'd28204; 6'd34: s = 15'd28714; 6'd35: s = 15'd29196;
            6'd36: s = 15'd29648; 6'd37: s = 15'd30072; 6'd38: s = 15'd30466;
            6'd39: s = 15'd30830; 6'd40: s = 15'd31163; 6'd41: s = 15'd31466;
            6'd42: s = 15'd31738; 6'd43: s = 15'd31978; 6'd44: s = 15'd32187;
            6'd45: s = 15'd32364; 6'd46: s = 15'd32509; 6'd47: s = 15'd32622;
            6'd48: s = 15'd32702; 6'd49: s = 15'd32751; 6'd50: s = 15'd32767;
            default: s = 15'd0;
        endcase
        return s;
    endfunction

endpackage

// File: sv/sinc_interpolator.sv
// channel  | signals                           | transaction
// in       | in_valid, in_ready, in_data       | load a sample or request a point
// out      | out_valid, out_ready, out_data    | one interpolated point per request
// cfg      | cfg_valid, cfg_ready, cfg_index,  | register write, always ready
//          | cfg_data                          |
//
// A load is taken in the idle state, which stays ready for the next item.
// Every point passes through the 20-step shared divider; any point that is
// not on the grid passes again for its sine index and once per stored sample.
// rst_n clears the record and the configuration registers; the sample store is not cleared.
// A finished point waits in the output register while the next item is taken;
// a further point holds in the controller until that register drains.
module sinc_interpolator #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sinci_pkg::sinci_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sinci_pkg::sinci_out_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_data
);
    import sinci_pkg::*;

    sinci_cmd_t    cmd;
    sinci_status_t status;

    assign cfg_ready = 1'b1;

    sinci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (in_data.opcode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sinci_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// File: sv/sinci_div.sv
module sinci_div #(
    parameter int DW = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sinci_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [DW-1:0]                     divisor,
    output logic                              busy,
    output logic [sinci_pkg::DIVIDEND_W-1:0]  quotient,
    output logic [DW-1:0]                     remainder
);
    import sinci_pkg::*;

    localparam int CNTW = $clog2(DIVIDEND_W + 1);

    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [DW-1:0]         r_reg;
    logic [DW-1:0]         d_reg;
    logic [DW:0]           trial;
    logic                  ge;

    assign trial = {r_reg, q_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = CNTW'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIVIDEND_W-2:0], ge};
            r_reg <= ge ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// File: sv/sinci_datapath.sv
module sinci_datapath #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sinci_pkg::sinci_cmd_t    cmd,
    output sinci_pkg::sinci_status_t status,
    input  sinci_pkg::sinci_in_t     in_data,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [10:0]              cfg_data,
    output sinci_pkg::sinci_out_t    out_data
);
    import sinci_pkg::*;

    localparam int DEPTH = MAX_POINTS / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(DEPTH * 50 + 1024);
    localparam int SDW   = DW + 1;

    logic [2:0]         timebase_reg;
    logic [10:0]        point_count_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [9:0]         first_offset_reg, first_offset_next;
    logic               offset_found_reg, offset_found_next;

    logic [7:0]         store [DEPTH];
    logic [7:0]         rd_reg;
    logic [9:0]         pos_reg, idx_reg, m_reg;
    logic [5:0]         k_reg;
    logic               m_ok_reg;
    logic [14:0]        sq_reg;
    logic [29:0]        c1_reg;
    logic [35:0]        c_reg;
    logic [42:0]        num_reg;
    logic [CW-1:0]      n_reg;
    logic signed [DW:0] den_reg;
    logic               parity_reg;
    logic [31:0]        acc_reg;
    logic [7:0]         res_reg;
    sinci_out_t         out_reg;

    logic [5:0]            delta;
    logic                  restart, beyond, nonzero, store_ok;
    logic [CW-1:0]         cnt_base;
    logic                  found_base;
    logic [9:0]            off_base;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend, quot;
    logic [DW-1:0]         div_divisor, rem, aden;
    logic                  div_busy;
    logic [6:0]            j_raw, j_fold;
    logic [31:0]           mag, whole;
    logic                  neg;
    logic [AW-1:0]         rd_addr;

    assign delta   = delta_of(timebase_reg);
    assign restart = in_data.position == 10'd0;
    assign beyond  = (32'(in_data.position) >= 32'(point_count_reg))
                  || (32'(in_data.position) >= 32'(MAX_POINTS));
    assign nonzero = in_data.sample != 8'd0;

    assign cnt_base   = restart ? '0 : count_reg;
    assign found_base = restart ? 1'b0 : offset_found_reg;
    assign off_base   = restart ? 10'd0 : first_offset_reg;
    assign store_ok   = cmd.accept_load && !beyond && nonzero
                     && (32'(cnt_base) < 32'(DEPTH));

    always_comb
    begin
        count_next        = count_reg;
        first_offset_next = first_offset_reg;
        offset_found_next = offset_found_reg;
        if (cmd.accept_load)
        begin
            count_next        = cnt_base;
            first_offset_next = off_base;
            offset_found_next = found_base;
            if (!beyond && nonzero)
            begin
                if (!found_base)
                begin
                    first_offset_next = in_data.position;
                    offset_found_next = 1'b1;
                end
                if (32'(cnt_base) < 32'(DEPTH))
                    count_next = cnt_base + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timebase_reg     <= 3'd0;
            point_count_reg  <= 11'd1024;
            count_reg        <= '0;
            first_offset_reg <= 10'd0;
            offset_found_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            first_offset_reg <= first_offset_next;
            offset_found_reg <= offset_found_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIMEBASE:    timebase_reg    <= cfg_data[2:0];
                    CFG_POINT_COUNT: point_count_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    assign rd_addr = cmd.mem_rd_term ? n_reg[AW-1:0] : AW'(m_reg);

    always_ff @(posedge clk)
    begin
        if (store_ok)
            store[cnt_base[AW-1:0]] <= in_data.sample;
        if (cmd.mem_rd_term || cmd.mem_rd_grid)
            rd_reg <= store[rd_addr];
    end

    assign aden = den_reg[DW] ? DW'(-den_reg) : DW'(den_reg);

    assign div_start = cmd.div_start_mk || cmd.div_start_j || cmd.term_div;

    always_comb
    begin
        priority if (cmd.term_div)
        begin
            div_dividend = num_reg[42:23];
            div_divisor  = aden;
        end
        else if (cmd.div_start_j)
        begin
            div_dividend = DIVIDEND_W'(k_reg) * DIVIDEND_W'(100);
            div_divisor  = DW'(delta);
        end
        else
        begin
            div_dividend = DIVIDEND_W'(idx_reg);
            div_divisor  = DW'(delta);
        end
    end

    sinci_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (quot),
        .remainder (rem)
    );

    // fold the sine index into the quarter wave
    assign j_raw  = quot[6:0];
    assign j_fold = (j_raw > 7'd50) ? 7'd100 - j_raw : j_raw;

    assign mag   = 32'(quot);
    assign neg   = parity_reg ^ den_reg[DW];
    assign whole = (32'd0 - acc_reg) >> 8;

    always_ff @(posedge clk)
    begin
        if (cmd.accept_read)
        begin
            pos_reg <= in_data.position;
            idx_reg <= (in_data.position > first_offset_reg)
                     ? in_data.position - first_offset_reg : in_data.position;
        end
        if (cmd.mk_latch)
        begin
            m_reg    <= quot[9:0];
            k_reg    <= rem[5:0];
            m_ok_reg <= 32'(quot) < 32'(count_reg);
        end
        if (cmd.sine_load)
            sq_reg <= sine_q15(j_fold[5:0]);
        if (cmd.const1)
            c1_reg <= 30'(sq_reg) * 30'(INV_PI_Q16);
        if (cmd.const2)
        begin
            c_reg      <= 36'(c1_reg) * 36'(delta);
            n_reg      <= '0;
            den_reg    <= SDW'(idx_reg);
            parity_reg <= m_reg[0];
            acc_reg    <= 32'd0;
        end
        if (cmd.grid_res)
            res_reg <= m_ok_reg ? rd_reg : 8'd0;
        if (cmd.term_mul)
            num_reg <= 43'(rd_reg) * 43'(c_reg);
        if (cmd.term_acc)
        begin
            acc_reg    <= neg ? acc_reg - mag : acc_reg + mag;
            n_reg      <= n_reg + 1'b1;
            den_reg    <= den_reg - SDW'(delta);
            parity_reg <= ~parity_reg;
        end
        // truncate toward zero before taking the low byte
        if (cmd.sum_res)
            res_reg <= acc_reg[31] ? 8'(32'd0 - whole) : acc_reg[15:8];
        if (cmd.out_load)
        begin
            out_reg.value <= res_reg;
            out_reg.point <= pos_reg;
        end
    end

    assign status.div_busy   = div_busy;
    assign status.k_zero     = rem == '0;
    assign status.count_zero = count_reg == '0;
    assign status.last_term  = (32'(n_reg) + 32'd1) == 32'(count_reg);

    assign out_data = out_reg;

endmodule

// File: sv/sinci_ctrl.sv
module sinci_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     opcode,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  sinci_pkg::sinci_status_t status,
    output sinci_pkg::sinci_cmd_t    cmd
);
    import sinci_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_MK_START = 17'b00000000000000010,
        S_MK_WAIT  = 17'b00000000000000100,
        S_GRID_RD  = 17'b00000000000001000,
        S_GRID_RES = 17'b00000000000010000,
        S_J_START  = 17'b00000000000100000,
        S_J_WAIT   = 17'b00000000001000000,
        S_SINE     = 17'b00000000010000000,
        S_CONST1   = 17'b00000000100000000,
        S_CONST2   = 17'b00000001000000000,
        S_T_RD     = 17'b00000010000000000,
        S_T_MUL    = 17'b00000100000000000,
        S_T_DIV    = 17'b00001000000000000,
        S_T_WAIT   = 17'b00010000000000000,
        S_T_ACC    = 17'b00100000000000000,
        S_SUM_RES  = 17'b01000000000000000,
        S_OUT      = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (opcode)
                    begin
                        cmd.accept_read = 1'b1;
                        state_next      = S_MK_START;
                    end
                    else
                        cmd.accept_load = 1'b1;
                end
            end
            S_MK_START:
            begin
                cmd.div_start_mk = 1'b1;
                state_next       = S_MK_WAIT;
            end
            S_MK_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.mk_latch = 1'b1;
                    state_next   = status.k_zero ? S_GRID_RD : S_J_START;
                end
            end
            S_GRID_RD:
            begin
                cmd.mem_rd_grid = 1'b1;
                state_next      = S_GRID_RES;
            end
            S_GRID_RES:
            begin
                cmd.grid_res = 1'b1;
                state_next   = S_OUT;
            end
            S_J_START:
            begin
                cmd.div_start_j = 1'b1;
                state_next      = S_J_WAIT;
            end
            S_J_WAIT:
            begin
                if (!status.div_busy)
                    state_next = S_SINE;
            end
            S_SINE:
            begin
                cmd.sine_load = 1'b1;
                state_next    = S_CONST1;
            end
            S_CONST1:
            begin
                cmd.const1 = 1'b1;
                state_next = S_CONST2;
            end
            S_CONST2:
            begin
                cmd.const2 = 1'b1;
                state_next = status.count_zero ? S_SUM_RES : S_T_RD;
            end
            S_T_RD:
            begin
                cmd.mem_rd_term = 1'b1;
                state_next      = S_T_MUL;
            end
            S_T_MUL:
            begin
                cmd.term_mul = 1'b1;
                state_next   = S_T_DIV;
            end
            S_T_DIV:
            begin
                cmd.term_div = 1'b1;
                state_next   = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (!status.div_busy)
                    state_next = S_T_ACC;
            end
            S_T_ACC:
            begin
                cmd.term_acc = 1'b1;
                state_next   = status.last_term ? S_SUM_RES : S_T_RD;
            end
            S_SUM_RES:
            begin
                cmd.sum_res = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/sinci_checker.sv
module sinci_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input sinci_pkg::sinci_in_t  in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input sinci_pkg::sinci_out_t out_data
);
    import sinci_pkg::*;

    logic [9:0] last_point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_point_reg <= 10'd0;
        else if (in_valid && in_ready && in_data.opcode)
            last_point_reg <= in_data.position;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.opcode |=> in_ready)
        else $error("load did not complete in one cycle");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.opcode |=> !in_ready)
        else $error("input taken during a read");

    a_point_echo: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_data.point == last_point_reg)
        else $error("result point does not match request");

endmodule

bind sinc_interpolator sinci_checker u_sinci_checker (.*);
